[sv/grid_cursor_navigator_assert.svh]
// Assertion shorthands for the grid cursor navigator. They expect clk and arst_n in scope.
`ifndef GRID_CURSOR_NAVIGATOR_ASSERT_SVH
`define GRID_CURSOR_NAVIGATOR_ASSERT_SVH

// Same-cycle implication.
`define GCN_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid cursor navigator: same-cycle check failed");

// Next-cycle implication.
`define GCN_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid cursor navigator: next-cycle check failed");

`endif

[sv/gcn_pkg.sv]
package gcn_pkg;

	localparam int MAX_ITEMS = 1024;

	localparam int CNT_W     = 11;
	localparam int IDX_W     = 10;
	localparam int STEP_W    = 12;
	localparam int SLOT_W    = 16;
	localparam int REQ_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 64;

	localparam int MUL_W  = CNT_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	localparam int DIV_DW     = SLOT_W;
	localparam int DIV_SW     = CNT_W;
	localparam int DIV_STEPS  = DIV_DW / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [REQ_W-1:0] REQ_MOVE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SET  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SLOT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_ROWS = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ROWS_GO,
		ST_ROWS_WAIT,
		ST_PAGES_GO,
		ST_PAGES_WAIT,
		ST_DISPATCH,
		ST_COL,
		ST_CUR_GO,
		ST_CUR_WAIT,
		ST_MUL_STEP,
		ST_ROW,
		ST_MUL_WRAP,
		ST_WRAP,
		ST_FOLLOW,
		ST_PAGE_GO,
		ST_PAGE_WAIT,
		ST_MUL_AREA,
		ST_AREA_CHK,
		ST_SLOT_GO,
		ST_SLOT_WAIT,
		ST_MUL_IDX,
		ST_IDX_CHK,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/gcn_div.sv]
module gcn_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gcn_pkg::DIV_DW-1:0]   dividend,
	input  logic [gcn_pkg::DIV_SW-1:0]   divisor,
	output gcn_pkg::div_stat_t           stat,
	output logic [gcn_pkg::DIV_DW-1:0]   quotient,
	output logic [gcn_pkg::DIV_SW-1:0]   remainder
);
	import gcn_pkg::*;

	logic [DIV_DW-1:0]    dvd_q;
	logic [DIV_SW-1:0]    rem_q;
	logic [DIV_SW-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_SW:0]   r1;
	logic [DIV_SW:0]   r1n;
	logic [DIV_SW:0]   r2;
	logic [DIV_SW:0]   r2n;
	logic              ge1;
	logic              ge2;

	// two restoring steps per cycle
	always_comb begin
		r1  = {rem_q, dvd_q[DIV_DW-1]};
		ge1 = r1 >= {1'b0, dsr_q};
		r1n = ge1 ? r1 - {1'b0, dsr_q} : r1;
		r2  = {r1n[DIV_SW-1:0], dvd_q[DIV_DW-2]};
		ge2 = r2 >= {1'b0, dsr_q};
		r2n = ge2 ? r2 - {1'b0, dsr_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DW-3:0], ge1, ge2};
			rem_q <= r2n[DIV_SW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

[sv/grid_cursor_navigator.sv]
// Cursor and scroll window over a row-major grid. One request is taken at a time and gives one
// result; the block is not ready while a request is in work. All divisions run on one shared
// divider that retires two quotient bits per cycle, and all products on one 12x12 multiplier
// with a registered product. A move that wraps above the top row also passes the wrap multiply
// and wrap states, and an out-of-range set-cursor request, a move on an empty grid or an unused
// code goes straight to the result; the next request can be taken as soon as the result is
// offered. Each configuration write to a known index recomputes the row and page totals with
// two divisions, during which the request and configuration channels are not ready.
module grid_cursor_navigator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gcn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gcn_pkg::CNT_W-1:0]         cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// col_step[11:0], row_step[23:12], target_index[33:24], slot_number[49:34], zero[55:50]
	input  logic [gcn_pkg::S_DATA_W-1:0]      s_tdata,
	// req_type[1:0]
	input  logic [gcn_pkg::REQ_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// cursor_pos[9:0], window_top[19:10], moved[20], row_total[31:21], page_total[42:32],
	// page_now[52:43], slot_item[62:53], slot_valid[63]
	output logic [gcn_pkg::M_DATA_W-1:0]      m_tdata
);
	import gcn_pkg::*;

	st_t state_q;
	st_t state_d;

	logic [CNT_W-1:0] item_count_q;
	logic [CNT_W-1:0] columns_q;
	logic [CNT_W-1:0] vis_rows_q;
	logic [CNT_W-1:0] cnt_eff;
	logic [CNT_W-1:0] cols_eff;
	logic [CNT_W-1:0] vis_eff;
	logic             cfg_known;

	logic [IDX_W-1:0] cursor_q;
	logic [IDX_W-1:0] top_q;
	logic [IDX_W-1:0] page_now_q;
	logic [CNT_W-1:0] rows_q;
	logic [CNT_W-1:0] pages_q;

	logic [REQ_W-1:0]         req_q;
	logic signed [STEP_W-1:0] col_step_q;
	logic signed [STEP_W-1:0] row_step_q;
	logic [IDX_W-1:0]         target_q;
	logic [SLOT_W-1:0]        slot_q;

	logic [IDX_W-1:0]         cur_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0]        prod_u;
	logic                     moved_q;
	logic [IDX_W-1:0]         slot_item_q;
	logic                     slot_valid_q;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic                out_free;

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;

	logic              div_start;
	logic [DIV_DW-1:0] div_dividend;
	logic [DIV_SW-1:0] div_divisor;
	div_stat_t         div_stat;
	logic [DIV_DW-1:0] div_quo;
	logic [DIV_SW-1:0] div_rem;

	logic [CNT_W:0]   rows_num;
	logic [CNT_W:0]   pages_num;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] rows_m1;
	logic [CNT_W-1:0] rows_m2;
	logic [CNT_W-1:0] win_row;
	logic             target_ok;

	logic signed [IDX_W+2:0] col_sum;
	logic                    col_under;
	logic                    col_over;
	logic [IDX_W-1:0]        col_next;

	logic signed [PROD_W:0]  row_next;
	logic                    row_under;
	logic                    row_over;
	logic signed [IDX_W+2:0] row_add;

	logic [PROD_W-1:0] wrap_idx;
	logic [PROD_W-1:0] wrap_back;
	logic              wrap_over;

	logic [CNT_W-1:0] f_max_top;
	logic [IDX_W-1:0] f_top1;
	logic [CNT_W:0]   f_lim;
	logic [CNT_W:0]   f_top2;
	logic [CNT_W:0]   f_top3;

	logic              area_ok;
	logic              slot_near;
	logic [PROD_W-1:0] idx_sum;
	logic              idx_ok;

	gcn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign cnt_eff   = (item_count_q > CNT_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : item_count_q;
	assign cols_eff  = (columns_q == '0) ? CNT_W'(1) : columns_q;
	assign vis_eff   = (vis_rows_q == '0) ? CNT_W'(1) : vis_rows_q;
	assign cfg_known = (cfg_index == CFG_ITEM_COUNT) || (cfg_index == CFG_COLUMNS)
		|| (cfg_index == CFG_VISIBLE_ROWS);
	assign out_free  = !m_tvalid_q || m_tready;
	assign prod_u    = $unsigned(prod_q);

	always_comb begin
		rows_num  = {1'b0, cnt_eff} + {1'b0, cols_eff} - (CNT_W+1)'(1);
		pages_num = {1'b0, rows_q} + {1'b0, vis_eff} - (CNT_W+1)'(1);
		cnt_m1    = cnt_eff - CNT_W'(1);
		rows_m1   = rows_q - CNT_W'(1);
		rows_m2   = rows_q - CNT_W'(2);
		win_row   = {1'b0, top_q} + {1'b0, row_q};
		target_ok = {1'b0, target_q} < cnt_eff;

		// linear column wrap
		col_sum   = $signed({3'b000, cursor_q}) + $signed({col_step_q[STEP_W-1], col_step_q});
		col_under = col_sum < 0;
		col_over  = col_sum >= $signed({2'b00, cnt_eff});
		if (col_under) begin
			col_next = cnt_m1[IDX_W-1:0];
		end else if (col_over) begin
			col_next = '0;
		end else begin
			col_next = col_sum[IDX_W-1:0];
		end

		row_next  = $signed({{(PROD_W+1-IDX_W){1'b0}}, cur_q}) + $signed({prod_q[PROD_W-1], prod_q});
		row_under = row_next < 0;
		row_over  = row_next >= $signed({{(PROD_W+1-CNT_W){1'b0}}, cnt_eff});
		row_add   = $signed({3'b000, row_q}) + $signed({row_step_q[STEP_W-1], row_step_q});

		// land on the last row, one row higher if that slot is past the end
		wrap_idx  = prod_u + {{(PROD_W-IDX_W){1'b0}}, col_q};
		wrap_over = wrap_idx >= {{(PROD_W-CNT_W){1'b0}}, cnt_eff};
		wrap_back = wrap_idx - {{(PROD_W-CNT_W){1'b0}}, cols_eff};

		f_max_top = (rows_q > vis_eff) ? rows_q - vis_eff : '0;
		f_top1    = (row_q < top_q) ? row_q : top_q;
		f_lim     = {2'b00, f_top1} + {1'b0, vis_eff};
		f_top2    = ({2'b00, row_q} >= f_lim)
			? {2'b00, row_q} - {1'b0, vis_eff} + (CNT_W+1)'(1) : {2'b00, f_top1};
		f_top3    = (f_top2 > {1'b0, f_max_top}) ? {1'b0, f_max_top} : f_top2;

		area_ok   = {{(PROD_W-SLOT_W){1'b0}}, slot_q} < prod_u;
		// drop a slot whose row or column lies past every item
		slot_near = (div_quo[DIV_DW-1:IDX_W] == '0) && (div_rem[DIV_SW-1:IDX_W] == '0);
		idx_sum   = prod_u + {{(PROD_W-IDX_W){1'b0}}, col_q};
		idx_ok    = idx_sum < {{(PROD_W-CNT_W){1'b0}}, cnt_eff};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_valid) begin
					if (cfg_known) begin
						state_d = ST_ROWS_GO;
					end
				end else if (s_tvalid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_ROWS_GO:    state_d = ST_ROWS_WAIT;
			ST_ROWS_WAIT:  if (div_stat.done) state_d = ST_PAGES_GO;
			ST_PAGES_GO:   state_d = ST_PAGES_WAIT;
			ST_PAGES_WAIT: if (div_stat.done) state_d = ST_IDLE;
			ST_DISPATCH: begin
				unique case (req_q)
					REQ_MOVE: state_d = (cnt_eff != '0) ? ST_COL : ST_DONE;
					REQ_SET:  state_d = target_ok ? ST_CUR_GO : ST_DONE;
					REQ_SLOT: state_d = ST_MUL_AREA;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_COL:      state_d = ST_CUR_GO;
			ST_CUR_GO:   state_d = ST_CUR_WAIT;
			ST_CUR_WAIT: begin
				if (div_stat.done) begin
					state_d = (req_q == REQ_MOVE) ? ST_MUL_STEP : ST_FOLLOW;
				end
			end
			ST_MUL_STEP:  state_d = ST_ROW;
			ST_ROW:       state_d = row_under ? ST_MUL_WRAP : ST_FOLLOW;
			ST_MUL_WRAP:  state_d = ST_WRAP;
			ST_WRAP:      state_d = ST_FOLLOW;
			ST_FOLLOW:    state_d = ST_PAGE_GO;
			ST_PAGE_GO:   state_d = ST_PAGE_WAIT;
			ST_PAGE_WAIT: if (div_stat.done) state_d = ST_DONE;
			ST_MUL_AREA:  state_d = ST_AREA_CHK;
			ST_AREA_CHK:  state_d = area_ok ? ST_SLOT_GO : ST_DONE;
			ST_SLOT_GO:   state_d = ST_SLOT_WAIT;
			ST_SLOT_WAIT: begin
				if (div_stat.done) begin
					state_d = slot_near ? ST_MUL_IDX : ST_DONE;
				end
			end
			ST_MUL_IDX:   state_d = ST_IDX_CHK;
			ST_IDX_CHK:   state_d = ST_DONE;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cfg_ready    = state_q == ST_IDLE;
		s_tready     = (state_q == ST_IDLE) && !cfg_valid;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = cols_eff;
		mul_a        = '0;
		mul_b        = $signed({1'b0, cols_eff});
		unique case (state_q)
			ST_ROWS_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_DW'(rows_num);
			end
			ST_PAGES_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_DW'(pages_num);
				div_divisor  = vis_eff;
			end
			ST_CUR_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_DW'(cur_q);
			end
			ST_SLOT_GO: begin
				div_start    = 1'b1;
				div_dividend = slot_q;
			end
			ST_PAGE_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_DW'(top_q);
				div_divisor  = vis_eff;
			end
			ST_MUL_STEP: mul_a = row_step_q;
			ST_MUL_WRAP: mul_a = $signed({1'b0, rows_m1});
			ST_MUL_AREA: mul_a = $signed({1'b0, vis_eff});
			ST_MUL_IDX:  mul_a = $signed({1'b0, win_row});
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			item_count_q <= '0;
			columns_q    <= CNT_W'(1);
			vis_rows_q   <= CNT_W'(1);
			cursor_q     <= '0;
			top_q        <= '0;
			page_now_q   <= '0;
			rows_q       <= '0;
			pages_q      <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready && cfg_known) begin
				unique case (cfg_index)
					CFG_ITEM_COUNT:   item_count_q <= cfg_data;
					CFG_COLUMNS:      columns_q    <= cfg_data;
					CFG_VISIBLE_ROWS: vis_rows_q   <= cfg_data;
					default: begin
					end
				endcase
				cursor_q   <= '0;
				top_q      <= '0;
				page_now_q <= '0;
			end
			if (div_stat.done) begin
				unique case (state_q)
					ST_ROWS_WAIT:  rows_q     <= div_quo[CNT_W-1:0];
					ST_PAGES_WAIT: pages_q    <= div_quo[CNT_W-1:0];
					ST_PAGE_WAIT:  page_now_q <= div_quo[IDX_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_FOLLOW) begin
				cursor_q <= cur_q;
				top_q    <= f_top3[IDX_W-1:0];
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					req_q      <= s_tuser;
					col_step_q <= s_tdata[11:0];
					row_step_q <= s_tdata[23:12];
					target_q   <= s_tdata[33:24];
					slot_q     <= s_tdata[49:34];
				end
			end
			ST_DISPATCH: begin
				moved_q      <= 1'b0;
				slot_item_q  <= '0;
				slot_valid_q <= 1'b0;
				cur_q        <= target_q;
			end
			ST_COL: cur_q <= col_next;
			ST_MUL_STEP, ST_MUL_WRAP, ST_MUL_AREA, ST_MUL_IDX: begin
				prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			end
			ST_CUR_WAIT, ST_SLOT_WAIT: begin
				if (div_stat.done) begin
					row_q <= div_quo[IDX_W-1:0];
					col_q <= div_rem[IDX_W-1:0];
				end
			end
			ST_ROW: begin
				if (!row_under) begin
					if (row_over) begin
						cur_q <= col_q;
						row_q <= '0;
					end else begin
						cur_q <= row_next[IDX_W-1:0];
						row_q <= row_add[IDX_W-1:0];
					end
				end
			end
			ST_WRAP: begin
				cur_q <= wrap_over ? wrap_back[IDX_W-1:0] : wrap_idx[IDX_W-1:0];
				row_q <= wrap_over ? rows_m2[IDX_W-1:0] : rows_m1[IDX_W-1:0];
			end
			ST_FOLLOW: moved_q <= (req_q == REQ_MOVE) && (cur_q != cursor_q);
			ST_IDX_CHK: begin
				if (idx_ok) begin
					slot_item_q  <= idx_sum[IDX_W-1:0];
					slot_valid_q <= 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {slot_valid_q, slot_item_q, page_now_q, pages_q, rows_q,
						moved_q, top_q, cursor_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "grid_cursor_navigator_assert.svh"

	`GCN_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`GCN_ASSERT_IMPL(a_div_owned, div_stat.busy || div_stat.done, state_q == ST_ROWS_WAIT || state_q == ST_PAGES_WAIT || state_q == ST_CUR_WAIT || state_q == ST_SLOT_WAIT || state_q == ST_PAGE_WAIT)
	`GCN_ASSERT_IMPL(a_cursor_in_range, state_q == ST_IDLE && cnt_eff != '0, CNT_W'(cursor_q) < cnt_eff)
	`GCN_ASSERT_IMPL(a_result_from_done, $rose(m_tvalid_q), $past(state_q == ST_DONE))

endmodule

[verif/tb_grid_cursor_navigator.sv]
module tb_grid_cursor_navigator;
	timeunit 1ns;
	timeprecision 1ps;

	import gcn_pkg::*;

	localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 10000;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic [5:0]        pad;
		logic [SLOT_W-1:0] slot_number;
		logic [IDX_W-1:0]  target_index;
		logic [STEP_W-1:0] row_step;
		logic [STEP_W-1:0] col_step;
	} nav_req_t;

	typedef struct packed {
		logic             slot_valid;
		logic [IDX_W-1:0] slot_item;
		logic [IDX_W-1:0] page_now;
		logic [CNT_W-1:0] page_total;
		logic [CNT_W-1:0] row_total;
		logic             moved;
		logic [IDX_W-1:0] window_top;
		logic [IDX_W-1:0] cursor_pos;
	} nav_result_t;

	typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_HOLD} op_kind_e;

	typedef struct {
		op_kind_e             kind;
		logic [REQ_W-1:0]     req;
		nav_req_t             data;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [CNT_W-1:0]     cfg_val;
		int                   gap;
	} nav_op_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CNT_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic [REQ_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;

	nav_op_t      nav_plan[$];
	nav_result_t  nav_expected[$];
	int           err_cnt = 0;
	int           gap_left = 0;
	int           rx_stall = 0;
	logic         rx_calm = 1'b0;
	int           idle_cycles = 0;

	logic [CNT_W-1:0] cnt_m = '0;
	logic [CNT_W-1:0] cols_m = 11'd1;
	logic [CNT_W-1:0] vis_m = 11'd1;
	int               cursor_m = 0;
	int               top_m = 0;

	int plan_cnt = 0;
	int plan_cols = 1;
	int plan_vis = 1;

	grid_cursor_navigator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic void track_window(int cols, int vis, int rows);
		int row, max_top;
		row = cursor_m / cols;
		max_top = (rows > vis) ? rows - vis : 0;
		if (row < top_m) top_m = row;
		if (row >= top_m + vis) top_m = row - vis + 1;
		if (top_m > max_top) top_m = max_top;
	endfunction

	function automatic nav_result_t predict_nav(logic [REQ_W-1:0] kind, nav_req_t rq);
		int count, cols, vis, rows, cur, prev, nxt, dcol, drow, slot, idx;
		nav_result_t res;
		res = '0;
		count = (int'(cnt_m) > MAX_ITEMS) ? MAX_ITEMS : int'(cnt_m);
		cols = (cols_m == 0) ? 1 : int'(cols_m);
		vis = (vis_m == 0) ? 1 : int'(vis_m);
		rows = (count == 0) ? 0 : (count + cols - 1) / cols;
		case (kind)
		REQ_MOVE: begin
			if (count > 0) begin
				dcol = int'($signed(rq.col_step));
				drow = int'($signed(rq.row_step));
				prev = cursor_m;
				cur = prev;
				if (dcol != 0) begin
					cur += dcol;
					if (cur < 0) cur = count - 1;
					if (cur >= count) cur = 0;
				end
				if (drow != 0) begin
					nxt = cur + drow * cols;
					if (nxt < 0) begin
						nxt = (rows - 1) * cols + cur % cols;
						if (nxt >= count) nxt -= cols;
					end else if (nxt >= count) begin
						nxt = cur % cols;
					end
					cur = nxt;
				end
				cursor_m = cur;
				track_window(cols, vis, rows);
				res.moved = (cur != prev);
			end
		end
		REQ_SET: begin
			if (int'(rq.target_index) < count) begin
				cursor_m = int'(rq.target_index);
				track_window(cols, vis, rows);
			end
		end
		REQ_SLOT: begin
			slot = int'(rq.slot_number);
			if (slot < cols * vis) begin
				idx = (top_m + slot / cols) * cols + slot % cols;
				if (idx < count) begin
					res.slot_item = IDX_W'(idx);
					res.slot_valid = 1'b1;
				end
			end
		end
		default: begin
		end
		endcase
		res.cursor_pos = IDX_W'(cursor_m);
		res.window_top = IDX_W'(top_m);
		res.row_total = CNT_W'(rows);
		res.page_total = CNT_W'((rows == 0) ? 0 : (rows + vis - 1) / vis);
		res.page_now = IDX_W'(top_m / vis);
		return res;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
		logic hit;
		hit = 1'b1;
		case (idx)
		CFG_ITEM_COUNT:   cnt_m = val;
		CFG_COLUMNS:      cols_m = val;
		CFG_VISIBLE_ROWS: vis_m = val;
		default:          hit = 1'b0;
		endcase
		if (hit) begin
			cursor_m = 0;
			top_m = 0;
		end
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	task automatic add_req(logic [REQ_W-1:0] kind, int col, int row, int tgt, int slot, int gap);
		nav_op_t op;
		op.kind = OP_REQ;
		op.req = kind;
		op.data = '0;
		op.data.col_step = STEP_W'(col);
		op.data.row_step = STEP_W'(row);
		op.data.target_index = IDX_W'(tgt);
		op.data.slot_number = SLOT_W'(slot);
		op.cfg_idx = '0;
		op.cfg_val = '0;
		op.gap = gap;
		nav_plan.push_back(op);
	endtask

	task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int val, int gap);
		nav_op_t op;
		op.kind = OP_CFG;
		op.req = '0;
		op.data = '0;
		op.cfg_idx = idx;
		op.cfg_val = CNT_W'(val);
		op.gap = gap;
		nav_plan.push_back(op);
		case (idx)
		CFG_ITEM_COUNT:   plan_cnt = val;
		CFG_COLUMNS:      plan_cols = val;
		CFG_VISIBLE_ROWS: plan_vis = val;
		default: begin
		end
		endcase
	endtask

	task automatic add_hold();
		nav_op_t op;
		op.kind = OP_HOLD;
		op.req = '0;
		op.data = '0;
		op.cfg_idx = '0;
		op.cfg_val = '0;
		op.gap = 0;
		nav_plan.push_back(op);
	endtask

	function automatic int rand_step(int span);
		int s;
		s = $urandom_range(0, 99);
		if (span > 2047) span = 2047;
		if (s < 55) return int'($urandom_range(0, 4)) - 2;
		if (s < 85) return int'($urandom_range(0, 2 * span)) - span;
		return int'($urandom);
	endfunction

	task automatic add_random_req(int gap);
		int r, ecnt, ecols, evis, erows, area;
		int col, row, tgt, slot;
		logic [REQ_W-1:0] kind;
		ecnt = (plan_cnt > MAX_ITEMS) ? MAX_ITEMS : plan_cnt;
		ecols = (plan_cols == 0) ? 1 : plan_cols;
		evis = (plan_vis == 0) ? 1 : plan_vis;
		erows = (ecnt == 0) ? 0 : (ecnt + ecols - 1) / ecols;
		area = ecols * evis + ecols;
		if (area > 65535) area = 65535;
		col = int'($urandom);
		row = int'($urandom);
		tgt = int'($urandom);
		slot = int'($urandom);
		r = $urandom_range(0, 99);
		if (r < 45) begin
			kind = REQ_MOVE;
			col = rand_step(ecols + 1);
			row = rand_step(erows + 1);
		end else if (r < 70) begin
			kind = REQ_SET;
			if (ecnt > 0 && $urandom_range(0, 3) != 0) tgt = $urandom_range(0, ecnt - 1);
		end else if (r < 96) begin
			kind = REQ_SLOT;
			if ($urandom_range(0, 4) != 0) slot = $urandom_range(0, area);
		end else begin
			kind = REQ_UNUSED;
		end
		add_req(kind, col, row, tgt, slot, gap);
	endtask

	always @(posedge clk or negedge arst_n)
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
			gap_left <= 0;
		end else begin : drive
			logic nv_s, nv_c;
			int ng;
			nav_op_t op;
			nv_s = s_tvalid;
			nv_c = cfg_valid;
			ng = gap_left;
			if (s_tvalid && s_tready) begin
				nav_expected.push_back(predict_nav(s_tuser, nav_req_t'(s_tdata)));
				nv_s = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_cfg(cfg_index, cfg_data);
				nv_c = 1'b0;
			end
			if (!nv_s && !nv_c) begin
				if (ng > 0) begin
					ng--;
				end else if (nav_plan.size() != 0) begin
					op = nav_plan[0];
					case (op.kind)
					OP_REQ: begin
						nv_s = 1'b1;
						s_tdata <= op.data;
						s_tuser <= op.req;
						ng = op.gap;
						void'(nav_plan.pop_front());
					end
					OP_CFG: begin
						if (nav_expected.size() == 0) begin
							nv_c = 1'b1;
							cfg_index <= op.cfg_idx;
							cfg_data <= op.cfg_val;
							ng = op.gap;
							void'(nav_plan.pop_front());
						end
					end
					default: begin
						if (nav_expected.size() == 0) void'(nav_plan.pop_front());
					end
					endcase
				end
			end
			s_tvalid <= nv_s;
			cfg_valid <= nv_c;
			gap_left <= ng;
		end

	always @(posedge clk or negedge arst_n)
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall <= 0;
			rx_calm <= 1'b0;
		end else begin : observe
			nav_result_t got, want;
			int ns;
			if (m_tvalid && m_tready) begin
				got = nav_result_t'(m_tdata);
				if (nav_expected.size() == 0) begin
					$error("result transaction with no request outstanding: %h", m_tdata);
					err_cnt++;
				end else begin
					want = nav_expected.pop_front();
					check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
					check_field("window_top", want.window_top, got.window_top);
					check_field("moved", want.moved, got.moved);
					check_field("row_total", want.row_total, got.row_total);
					check_field("page_total", want.page_total, got.page_total);
					check_field("page_now", want.page_now, got.page_now);
					check_field("slot_item", want.slot_item, got.slot_item);
					check_field("slot_valid", want.slot_valid, got.slot_valid);
				end
			end
			ns = rx_stall;
			if (ns > 0) ns--;
			if (ns == 0 && !rx_calm && $urandom_range(0, 7) == 0) ns = pick_gap();
			if ($urandom_range(0, 199) == 0) rx_calm <= ~rx_calm;
			rx_stall <= ns;
			m_tready <= (ns == 0);
		end

	always @(posedge clk)
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** grid_cursor_navigator: FAILED **");
				$finish;
			end
		end

	initial begin : stimulus
		int cnt_v [12];
		int cols_v [12];
		int vis_v [12];
		int ph, k, rot, j, calm, hold_at;
		cnt_v = '{1024, 1, 2047, 37, 100, 1000, 24, 0, 1023, 1024, 0, 0};
		cols_v = '{1024, 1, 0, 5, 7, 32, 4, 3, 1, 2047, 0, 0};
		vis_v = '{1024, 1, 0, 3, 4, 5, 10, 2, 7, 1, 0, 0};

		add_req(REQ_MOVE, 1, 1, 0, 0, 0);
		add_req(REQ_SLOT, 0, 0, 0, 0, 0);
		add_req(REQ_SET, 0, 0, 0, 0, 0);
		add_req(REQ_UNUSED, 0, 0, 0, 0, 0);
		add_cfg(CFG_UNUSED, 5, 0);
		add_req(REQ_UNUSED, 0, 0, 0, 0, 0);
		add_cfg(CFG_ITEM_COUNT, 10, 0);
		add_cfg(CFG_COLUMNS, 4, 0);
		add_cfg(CFG_VISIBLE_ROWS, 2, 0);
		add_req(REQ_MOVE, -1, 0, 0, 0, 0);
		add_req(REQ_MOVE, 1, 0, 0, 0, 0);
		add_req(REQ_MOVE, 0, -1, 0, 0, 0);
		add_req(REQ_SET, 0, 0, 3, 0, 0);
		add_req(REQ_MOVE, 0, -1, 0, 0, 0);
		add_req(REQ_SLOT, 0, 0, 0, 3, 0);
		add_req(REQ_MOVE, 0, 1, 0, 0, 0);
		add_req(REQ_SET, 0, 0, 9, 0, 0);
		add_req(REQ_MOVE, 1, 0, 0, 0, 0);
		add_req(REQ_SLOT, 0, 0, 0, 7, 0);
		add_req(REQ_SLOT, 0, 0, 0, 8, 0);
		add_req(REQ_SET, 0, 0, 10, 0, 0);
		add_req(REQ_SET, 0, 0, 1023, 0, 0);
		add_req(REQ_MOVE, -2048, 0, 0, 0, 0);
		add_req(REQ_MOVE, 2047, 0, 0, 0, 0);
		add_req(REQ_MOVE, 0, -2048, 0, 0, 0);
		add_req(REQ_MOVE, 0, 2047, 0, 0, 0);
		add_req(REQ_SLOT, 0, 0, 0, 65535, 0);
		add_req(REQ_MOVE, 0, 0, 0, 0, 0);

		for (ph = 0; ph < 12; ph++) begin
			if (ph >= 10) begin
				cnt_v[ph] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
					: $urandom_range(0, 120);
				cols_v[ph] = $urandom_range(0, 40);
				vis_v[ph] = $urandom_range(0, 12);
			end
			rot = $urandom_range(0, 2);
			for (j = 0; j < 3; j++) begin
				case ((rot + j) % 3)
				0:       add_cfg(CFG_ITEM_COUNT, cnt_v[ph], $urandom_range(0, 3));
				1:       add_cfg(CFG_COLUMNS, cols_v[ph], $urandom_range(0, 3));
				default: add_cfg(CFG_VISIBLE_ROWS, vis_v[ph], $urandom_range(0, 3));
				endcase
			end
			calm = ($urandom_range(0, 3) == 0);
			hold_at = (ph == 3 || $urandom_range(0, 1) == 0) ? $urandom_range(5, 60) : -1;
			for (k = 0; k < 70; k++) begin
				if (k == hold_at) add_hold();
				add_random_req(calm ? 0 : pick_gap());
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (nav_plan.size() != 0 || s_tvalid || cfg_valid || nav_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("** grid_cursor_navigator: PASSED **");
		else
			$display("** grid_cursor_navigator: FAILED **");
		$finish;
	end

endmodule
